// File: src/dsp_pkg.sv
// Shared constants and types of the divisor-sum perfect-number test.
// Used by the channel interfaces, the serial divider and the top level.
// Depends on nothing.
`default_nettype none

package dsp_pkg;

    // Fixed field widths of the channels.
    localparam int NUMBER_FIELD_WIDTH = 32;
    localparam int SUM_WIDTH          = 35;

    // Number of input bits taken into account.
    localparam int NUMBER_WIDTH = 32;

    // A tested divisor never exceeds floor(sqrt(n)) + 1.
    localparam int DIVISOR_WIDTH = (NUMBER_WIDTH + 1) / 2 + 1;

    // Accumulator for the sum of all divisors, n included.
    localparam int ACC_WIDTH = NUMBER_WIDTH + 4;

    // Bit counter of the serial divider.
    localparam int COUNT_WIDTH = $clog2(NUMBER_WIDTH + 1);

    typedef logic [NUMBER_WIDTH-1:0]  number_t;
    typedef logic [DIVISOR_WIDTH-1:0] divisor_t;
    typedef logic [ACC_WIDTH-1:0]     acc_t;
    typedef logic [COUNT_WIDTH-1:0]   count_t;

    typedef struct packed {
        logic     start;
        number_t  dividend;
        divisor_t divisor;
    } div_req_t;

    typedef struct packed {
        logic     done;
        number_t  quotient;
        divisor_t remainder;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_CHECK = 5'b00100,
        S_ADDD  = 5'b01000,
        S_FINAL = 5'b10000
    } state_t;

endpackage

`default_nettype wire

// File: src/dsp_if.sv
// Valid/ready channel interfaces for the number items and the result items.
// Depends on dsp_pkg for the field widths.
`default_nettype none

interface dsp_num_if;
    logic                                   valid;
    logic                                   ready;
    logic [dsp_pkg::NUMBER_FIELD_WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface dsp_res_if;
    logic                          valid;
    logic                          ready;
    logic [dsp_pkg::SUM_WIDTH-1:0] divisor_sum;
    logic                          is_perfect;

    modport source (output valid, output divisor_sum, output is_perfect, input ready);
    modport sink   (input valid, input divisor_sum, input is_perfect, output ready);
endinterface

`default_nettype wire

// File: src/dsp_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on dsp_pkg for widths and the request/response structs.
`default_nettype none

module dsp_serial_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dsp_pkg::div_req_t req,
    output dsp_pkg::div_rsp_t      rsp
);
    import dsp_pkg::*;

    logic     busy_reg, busy_next;
    logic     done_reg, done_next;
    count_t   cnt_reg, cnt_next;
    number_t  quo_reg, quo_next;
    divisor_t rem_reg, rem_next;
    divisor_t div_reg, div_next;

    logic [DIVISOR_WIDTH:0] trial;
    logic [DIVISOR_WIDTH:0] diff;
    logic                   qbit;

    // The dividend shifts out at the top while quotient bits shift in below.
    assign trial = {rem_reg, quo_reg[NUMBER_WIDTH-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign qbit  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = count_t'(NUMBER_WIDTH);
            quo_next  = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUMBER_WIDTH-2:0], qbit};
            rem_next = qbit ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
            cnt_next = cnt_reg - count_t'(1);
            if (cnt_reg == count_t'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

// File: src/divisor_sum_perfect_test.sv
// Top level of the divisor-sum perfect-number test: trial-division sequencer
// and result register. Depends on dsp_pkg, dsp_if.sv and dsp_serial_div.
//
// The block takes one number item at a time and returns one result item: the
// sum of the proper divisors of the number and a flag that is set when the
// number is nonzero and equal to that sum. Divisors d are tried from 1 upward
// in pairs (d, n/d) until n/d < d; each trial is a bit-serial division that
// the sequencer starts and the divider flags done, then a check and, when d
// divides n, an accumulation step. The result waits in an output register,
// so the next item is taken as soon as the sequencer is idle, even while the
// previous result has not yet been taken.
`default_nettype none

module divisor_sum_perfect_test (
    input  wire logic clk,
    input  wire logic rst_n,
    dsp_num_if.sink   item,
    dsp_res_if.source result
);
    import dsp_pkg::*;

    state_t   state_reg, state_next;
    number_t  n_reg, n_next;
    divisor_t d_reg, d_next;
    acc_t     total_reg, total_next;
    logic     start_reg, start_next;

    logic                 out_valid_reg, out_valid_next;
    logic [SUM_WIDTH-1:0] out_sum_reg, out_sum_next;
    logic                 out_perfect_reg, out_perfect_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic quo_below;
    logic exact;
    acc_t aliquot;

    dsp_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign div_req.start    = start_reg;
    assign div_req.dividend = n_reg;
    assign div_req.divisor  = d_reg;

    // Once n/d drops below d, every divisor pair has been seen.
    assign quo_below = (div_rsp.quotient < NUMBER_WIDTH'(d_reg));
    assign exact     = (div_rsp.remainder == '0);
    assign aliquot   = total_reg - ACC_WIDTH'(n_reg);

    assign item.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        n_next           = n_reg;
        d_next           = d_reg;
        total_next       = total_reg;
        start_next       = 1'b0;
        out_valid_next   = out_valid_reg;
        out_sum_next     = out_sum_reg;
        out_perfect_next = out_perfect_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    n_next     = NUMBER_WIDTH'(item.number);
                    d_next     = divisor_t'(1);
                    total_next = '0;
                    start_next = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (quo_below)
                begin
                    state_next = S_FINAL;
                end
                else if (exact)
                begin
                    // The partner divisor, unless equal to d, is added here, d itself next cycle.
                    if (div_rsp.quotient != NUMBER_WIDTH'(d_reg))
                    begin
                        total_next = total_reg + ACC_WIDTH'(div_rsp.quotient);
                    end
                    state_next = S_ADDD;
                end
                else
                begin
                    d_next     = d_reg + divisor_t'(1);
                    start_next = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_ADDD:
            begin
                total_next = total_reg + ACC_WIDTH'(d_reg);
                d_next     = d_reg + divisor_t'(1);
                start_next = 1'b1;
                state_next = S_DIV;
            end
            S_FINAL:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_sum_next     = SUM_WIDTH'(aliquot);
                    out_perfect_next = (n_reg != '0) && (aliquot == ACC_WIDTH'(n_reg));
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg           <= n_next;
        d_reg           <= d_next;
        total_reg       <= total_next;
        out_sum_reg     <= out_sum_next;
        out_perfect_reg <= out_perfect_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.divisor_sum = out_sum_reg;
    assign result.is_perfect  = out_perfect_reg;

endmodule

`default_nettype wire

// File: src/dsp_checker.sv
// Port-level checks of the divisor-sum perfect-number test, bound to the top.
// Depends on dsp_pkg for the field widths.
`default_nettype none

module dsp_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          item_valid,
    input wire logic                          item_ready,
    input wire logic                          result_valid,
    input wire logic                          result_ready,
    input wire logic [dsp_pkg::SUM_WIDTH-1:0] divisor_sum,
    input wire logic                          is_perfect
);

    // A stalled result item stays offered.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result item withdrawn while stalled");

    // A stalled result item keeps its payload.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(divisor_sum) && $stable(is_perfect))
        else $error("result payload changed while stalled");

    // A perfect flag comes only with a nonzero divisor sum.
    a_perfect_sum: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && is_perfect |-> divisor_sum != '0)
        else $error("perfect flag with zero divisor sum");

    // The block is busy with an item for at least the division after taking it.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("new item taken right after an accepted one");

    // No result can appear in the cycle right after an item was taken.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(item_valid && item_ready))
        else $error("result appeared one cycle after an item was taken");

endmodule

bind divisor_sum_perfect_test dsp_checker u_dsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .divisor_sum  (result.divisor_sum),
    .is_perfect   (result.is_perfect)
);

`default_nettype wire
